// ===== hw/rtl/kdms_pkg.sv =====
// ----------------------------------------------------------------------------
// kdms_pkg
// Types, widths and helpers shared by the k-d median split cells and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package kdms_pkg;

    localparam int KEY_W  = 32;
    localparam int IDX_W  = 6;
    localparam int RANK_W = 6;

    typedef struct packed {
        logic signed [KEY_W-1:0] point_x;
        logic signed [KEY_W-1:0] point_y;
        logic                    last_point;
    } t_point_in;

    typedef struct packed {
        logic [IDX_W-1:0]        point_index;
        logic                    side;
        logic signed [KEY_W-1:0] split_coord;
        logic                    overflow;
        logic                    last_result;
    } t_split_out;

    // A key travelling down the row, with the count of stored keys not above it.
    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [RANK_W-1:0] cnt;
    } t_token;

    // One stored point.
    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [RANK_W-1:0] rank;
    } t_entry;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_MOVE   = 2'd1,
        OP_HOLD   = 2'd2
    } t_cell_op;

    function automatic logic key_less(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/kdms_cell.sv =====
// ----------------------------------------------------------------------------
// kdms_cell
// One cell of the point row: holds a stored point and passes keys or entries on.
// ----------------------------------------------------------------------------
`default_nettype none

module kdms_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kdms_pkg::t_cell_op i_op,
    input  kdms_pkg::t_token  i_tok,
    input  kdms_pkg::t_entry  i_next,
    output kdms_pkg::t_token  o_tok,
    output kdms_pkg::t_entry  o_entry
);
    import kdms_pkg::*;

    t_token r_tok;
    t_token n_tok;
    t_entry r_ent;
    t_entry n_ent;
    logic   w_less;

    always_comb begin
        w_less      = key_less(i_tok.key, r_ent.key);
        n_tok       = i_tok;
        n_tok.valid = 1'b0;
        n_ent       = r_ent;
        unique case (i_op)
            OP_INSERT: begin
                if (i_tok.valid) begin
                    if (r_ent.valid) begin
                        n_tok.valid = 1'b1;
                        n_tok.cnt   = i_tok.cnt + RANK_W'(!w_less);
                        if (w_less) begin
                            n_ent.rank = r_ent.rank + RANK_W'(1);
                        end
                    end else begin
                        n_ent.valid = 1'b1;
                        n_ent.key   = i_tok.key;
                        n_ent.rank  = i_tok.cnt;
                    end
                end
            end
            OP_MOVE: begin
                n_ent = i_next;
            end
            OP_HOLD: begin
                n_ent = r_ent;
            end
            default: begin
                n_ent = r_ent;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
            r_ent.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
            r_ent <= n_ent;
        end
    end

    assign o_tok   = r_tok;
    assign o_entry = r_ent;

endmodule

`default_nettype wire

// ===== hw/rtl/kd_median_split.sv =====
// ----------------------------------------------------------------------------
// kd_median_split
// Median split of a set of 2-D points along a configurable axis.
// ----------------------------------------------------------------------------
//  Channel  Handshake                  Payload       Moves
//  input    i_in_valid / o_in_stall    i_in_data     one point per transfer
//  output   o_out_valid / i_out_stall  o_out_data    one result per transfer
//  config   i_cfg_we                   i_cfg_wdata   split axis register
//
//  Points load at one per cycle while the input is not stalled; each key
//  ripples down the cell row, one cell a cycle, ranking itself against the
//  stored points on its way. After the last point, a drain phase settles the
//  row and a find phase rotates it past cell 0 to locate the median; results
//  then leave at one per cycle in arrival order, held while output stalls.
//  Input is stalled from the last point until its final result has been taken
//  into the output register. Reset clears the row and control state.
// ----------------------------------------------------------------------------
`default_nettype none

module kd_median_split #(
    parameter int MAX_POINTS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_in_valid,
    input  kdms_pkg::t_point_in i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output kdms_pkg::t_split_out o_out_data,
    input  logic                i_out_stall
);
    import kdms_pkg::*;

    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_DRAIN = 4'b0010,
        ST_FIND  = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    t_state           r_state;
    logic             r_split_on_x;
    logic [CW-1:0]    r_count;
    logic             r_overflow;
    logic [CW-1:0]    r_timer;
    logic [CW-1:0]    r_emit;
    logic [KEY_W-1:0] r_split;
    logic             r_out_valid;
    t_split_out       r_out;

    logic             w_accept;
    logic             w_store;
    logic [KEY_W-1:0] w_key;
    logic [CW-1:0]    w_half;
    logic             w_emit_fire;
    logic             w_timer_done;
    t_cell_op         w_op;
    t_entry           w_tail_next;
    t_token           w_tok_in;
    t_token           w_tok [0:MAX_POINTS];
    t_entry           w_ent [0:MAX_POINTS-1];

    assign o_in_stall   = (r_state != ST_LOAD);
    assign w_accept     = i_in_valid && !o_in_stall;
    assign w_store      = w_accept && (r_count != CW'(MAX_POINTS));
    assign w_key        = r_split_on_x ? i_in_data.point_x : i_in_data.point_y;
    assign w_half       = r_count >> 1;
    assign w_timer_done = (r_timer == CW'(MAX_POINTS - 1));
    assign w_emit_fire  = (r_state == ST_EMIT) && (!r_out_valid || !i_out_stall);
    assign w_tok[0]     = w_tok_in;

    always_comb begin
        w_tok_in.valid = w_store;
        w_tok_in.key   = w_key;
        w_tok_in.cnt   = '0;

        unique case (r_state)
            ST_LOAD, ST_DRAIN: w_op = OP_INSERT;
            ST_FIND:           w_op = OP_MOVE;
            ST_EMIT:           w_op = w_emit_fire ? OP_MOVE : OP_HOLD;
            default:           w_op = OP_HOLD;
        endcase

        if (r_state == ST_FIND) begin
            w_tail_next = w_ent[0];
        end else begin
            w_tail_next       = w_ent[0];
            w_tail_next.valid = 1'b0;
        end
    end

    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
        t_entry w_next;
        if (g == MAX_POINTS - 1) begin : g_tail
            assign w_next = w_tail_next;
        end else begin : g_body
            assign w_next = w_ent[g+1];
        end
        kdms_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (w_op),
            .i_tok   (w_tok[g]),
            .i_next  (w_next),
            .o_tok   (w_tok[g+1]),
            .o_entry (w_ent[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_split_on_x <= 1'b0;
            r_count      <= '0;
            r_overflow   <= 1'b0;
            r_timer      <= '0;
            r_emit       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_split_on_x <= i_cfg_wdata;
            end

            unique case (r_state)
                ST_LOAD: begin
                    if (w_store) begin
                        r_count <= r_count + CW'(1);
                    end else if (w_accept) begin
                        r_overflow <= 1'b1;
                    end
                    if (w_accept && i_in_data.last_point) begin
                        r_state <= ST_DRAIN;
                        r_timer <= '0;
                    end
                end
                ST_DRAIN: begin
                    r_timer <= r_timer + CW'(1);
                    if (w_timer_done) begin
                        r_state <= ST_FIND;
                        r_timer <= '0;
                    end
                end
                ST_FIND: begin
                    r_timer <= r_timer + CW'(1);
                    if (w_ent[0].valid && (CW'(w_ent[0].rank) == w_half)) begin
                        r_split <= w_ent[0].key;
                    end
                    if (w_timer_done) begin
                        r_state <= ST_EMIT;
                        r_emit  <= '0;
                    end
                end
                ST_EMIT: begin
                    if (w_emit_fire) begin
                        r_emit <= r_emit + CW'(1);
                        if (r_emit + CW'(1) == r_count) begin
                            r_state    <= ST_LOAD;
                            r_count    <= '0;
                            r_overflow <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase

            if (w_emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_fire) begin
            r_out.point_index <= IDX_W'(r_emit);
            r_out.side        <= (CW'(w_ent[0].rank) < w_half) ? 1'b0 : 1'b1;
            r_out.split_coord <= r_split;
            r_out.overflow    <= r_overflow;
            r_out.last_result <= (r_emit + CW'(1) == r_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
